>>> hw/rtl/ldmc_pkg.sv
// shared types, constants and helper functions of the led doorbell mode controller
package ldmc_pkg;

    localparam int LINE_LENGTH     = 16;
    localparam int ANIMATION_COUNT = 4;

    localparam int IDX_W  = $clog2(LINE_LENGTH);
    localparam int CNT_W  = $clog2(LINE_LENGTH + 1);
    localparam int ANIM_W = (ANIMATION_COUNT > 4) ? $clog2(ANIMATION_COUNT) : 2;
    localparam int NIB_COUNT = 8;

    localparam logic [IDX_W-1:0]  LINE_LAST_IDX = IDX_W'(LINE_LENGTH - 1);
    localparam logic [ANIM_W-1:0] ANIM_LAST     = ANIM_W'(ANIMATION_COUNT - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int TICKS_W    = 10;
    localparam int FRAME_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;

    localparam logic [TICKS_W-1:0] RING_TICKS_RESET   = 10'd100;
    localparam logic [TICKS_W-1:0] NOTIFY_TICKS_RESET = 10'd300;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_BANG = 8'h21;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_BUTTON = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RING_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_TICKS = 2'd1;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RING   = 2'd1,
        MODE_NOTIFY = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_EOL   = 2'd1,
        CMD_PRESS = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [TICKS_W-1:0]   data;
    } t_cfg_wr;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } t_back_state;

    function automatic logic hex_is_digit(input logic [7:0] ch);
        hex_is_digit = (ch >= 8'h30 && ch <= 8'h39) ||
                       (ch >= 8'h41 && ch <= 8'h46) ||
                       (ch >= 8'h61 && ch <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = ch - 8'h30;
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            v = ch - 8'h37;
        end else begin
            v = ch - 8'h57;
        end
        hex_value = v[3:0];
    endfunction

endpackage

>>> hw/rtl/led_doorbell_mode_controller.sv
// top level of the led doorbell mode controller
//
// requests arrive on s_axis: tuser carries the kind (serial byte, button sample or
// frame tick), tdata the byte and the button level. a transfer is taken whenever
// the four-entry command queue has room. the front end drops button samples that
// are not a falling edge and request kind 3; everything else enters the queue.
// the back end executes one queued command per cycle unless a scan runs, the queue
// is empty or a tick waits for room in the result register; a line end starting
// with '#' runs a color scan over the line store, one byte per cycle.
// each frame tick produces one result on m_axis in the cycle after it is executed;
// the result register holds it until the receiver takes the transfer, and while
// it waits the back end keeps executing bytes, presses and line ends. a further
// tick then waits in the queue, and s_axis stalls once the queue is full.
// the configuration port writes ring_ticks (index 0) and notify_ticks (index 1);
// there is no read-back. synchronous reset returns the block to idle with
// an empty line store, color 0 and register defaults 100 and 300.
module led_doorbell_mode_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // serial_byte [7:0], button_level [8], zero fill
    input  logic [ldmc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // animation_index [1:0], frame_index [17:2], wrgb_color [49:18],
    // activity_led [50], zero fill
    output logic [ldmc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // mode [1:0]
    output logic [1:0]                        m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [ldmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ldmc_pkg::TICKS_W-1:0]      i_cfg_wdata
);

    logic                          w_push;
    ldmc_pkg::t_cmd                w_push_cmd;
    logic                          w_full;
    logic                          w_empty;
    ldmc_pkg::t_cmd                w_head;
    logic                          w_pop;
    ldmc_pkg::t_cfg_wr             w_cfg;
    logic [1:0]                    w_anim;
    logic [ldmc_pkg::FRAME_W-1:0]  w_frame;
    logic [ldmc_pkg::COLOR_W-1:0]  w_color;
    logic                          w_led;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_wdata;

    ldmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_req_type     (s_axis_tuser),
        .i_serial_byte  (s_axis_tdata[7:0]),
        .i_button_level (s_axis_tdata[8]),
        .i_full         (w_full),
        .o_ready        (s_axis_tready),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    ldmc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_empty    (w_empty),
        .o_head     (w_head)
    );

    ldmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_mode      (m_axis_tuser),
        .o_anim      (w_anim),
        .o_frame     (w_frame),
        .o_color     (w_color),
        .o_led       (w_led)
    );

    assign m_axis_tdata = {5'b0, w_led, w_color, w_frame, w_anim};

endmodule

>>> hw/rtl/ldmc_front.sv
// front end: accepts requests, tracks the button edge and turns requests into commands
module ldmc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_serial_byte,
    input  logic                 i_button_level,
    input  logic                 i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output ldmc_pkg::t_cmd       o_cmd
);

    logic r_prev_level;
    logic n_prev_level;
    logic w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_comb begin
        n_prev_level = r_prev_level;
        o_push       = 1'b0;
        o_cmd.kind   = ldmc_pkg::CMD_BYTE;
        o_cmd.data   = i_serial_byte;
        if (w_accept) begin
            unique case (i_req_type)
                ldmc_pkg::REQ_BYTE: begin
                    o_push = 1'b1;
                    if (i_serial_byte == ldmc_pkg::CHAR_CR ||
                        i_serial_byte == ldmc_pkg::CHAR_LF) begin
                        o_cmd.kind = ldmc_pkg::CMD_EOL;
                    end
                end
                ldmc_pkg::REQ_BUTTON: begin
                    // only a falling edge reaches the back end
                    n_prev_level = i_button_level;
                    if (!i_button_level && r_prev_level) begin
                        o_push     = 1'b1;
                        o_cmd.kind = ldmc_pkg::CMD_PRESS;
                    end
                end
                ldmc_pkg::REQ_TICK: begin
                    o_push     = 1'b1;
                    o_cmd.kind = ldmc_pkg::CMD_TICK;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
        end else begin
            r_prev_level <= n_prev_level;
        end
    end

endmodule

>>> hw/rtl/ldmc_queue.sv
// short command queue between front and back end
module ldmc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ldmc_pkg::t_cmd i_push_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ldmc_pkg::t_cmd o_head
);

    ldmc_pkg::t_cmd r_mem [ldmc_pkg::QUEUE_DEPTH];
    logic [ldmc_pkg::QPTR_W:0] r_wr;
    logic [ldmc_pkg::QPTR_W:0] r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[ldmc_pkg::QPTR_W] != r_rd[ldmc_pkg::QPTR_W]) &&
                     (r_wr[ldmc_pkg::QPTR_W-1:0] == r_rd[ldmc_pkg::QPTR_W-1:0]);
    assign o_head  = r_mem[r_rd[ldmc_pkg::QPTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[ldmc_pkg::QPTR_W-1:0]] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/ldmc_back.sv
// back end: line store, color parse sequencer, mode timer and result register
module ldmc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ldmc_pkg::t_cfg_wr             i_cfg,
    input  logic                          i_empty,
    input  ldmc_pkg::t_cmd                i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_mode,
    output logic [1:0]                    o_anim,
    output logic [ldmc_pkg::FRAME_W-1:0]  o_frame,
    output logic [ldmc_pkg::COLOR_W-1:0]  o_color,
    output logic                          o_led
);

    ldmc_pkg::t_back_state r_state, n_state;

    logic [7:0]                     r_store [ldmc_pkg::LINE_LENGTH];
    logic [7:0]                     n_store [ldmc_pkg::LINE_LENGTH];
    logic [ldmc_pkg::CNT_W-1:0]     r_count, n_count;
    ldmc_pkg::t_mode                r_mode, n_mode;
    logic [ldmc_pkg::ANIM_W-1:0]    r_anim, n_anim;
    logic [ldmc_pkg::FRAME_W-1:0]   r_frame, n_frame;
    logic [ldmc_pkg::TICKS_W-1:0]   r_ticks, n_ticks;
    logic [ldmc_pkg::COLOR_W-1:0]   r_color, n_color;
    logic                           r_press, n_press;
    logic                           r_led, n_led;
    logic [ldmc_pkg::TICKS_W-1:0]   r_ring_ticks;
    logic [ldmc_pkg::TICKS_W-1:0]   r_notify_ticks;

    // scan registers
    logic [ldmc_pkg::IDX_W-1:0]     r_k, n_k;
    logic [ldmc_pkg::IDX_W-1:0]     r_len, n_len;
    logic                           r_bad, n_bad;
    logic                           r_found, n_found;
    logic [3:0]                     r_nib [ldmc_pkg::NIB_COUNT];
    logic [3:0]                     n_nib [ldmc_pkg::NIB_COUNT];

    // result register
    logic                           r_out_valid, n_out_valid;
    ldmc_pkg::t_mode                r_out_mode, n_out_mode;
    logic [1:0]                     r_out_anim, n_out_anim;
    logic [ldmc_pkg::FRAME_W-1:0]   r_out_frame, n_out_frame;
    logic [ldmc_pkg::COLOR_W-1:0]   r_out_color, n_out_color;
    logic                           r_out_led, n_out_led;

    logic                           w_out_free;
    logic                           w_is_hash;
    logic [7:0]                     w_scan_byte;
    logic [ldmc_pkg::COLOR_W-1:0]   w_parsed;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_is_hash   = (r_store[0] == ldmc_pkg::CHAR_HASH);
    assign w_scan_byte = r_store[r_k];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ldmc_pkg::ST_RUN: begin
                if (o_pop && i_head.kind == ldmc_pkg::CMD_EOL && w_is_hash) begin
                    n_state = ldmc_pkg::ST_SCAN;
                end
            end
            ldmc_pkg::ST_SCAN: begin
                if (r_k == ldmc_pkg::LINE_LAST_IDX) begin
                    n_state = ldmc_pkg::ST_DONE;
                end
            end
            ldmc_pkg::ST_DONE: begin
                n_state = ldmc_pkg::ST_RUN;
            end
            default: begin
                n_state = ldmc_pkg::ST_RUN;
            end
        endcase
    end

    // outputs of the sequencer: a tick waits for room in the result register
    always_comb begin
        o_pop = (r_state == ldmc_pkg::ST_RUN) && !i_empty &&
                (i_head.kind != ldmc_pkg::CMD_TICK || w_out_free);
    end

    // color from the scanned digits
    always_comb begin
        w_parsed = '0;
        if (!r_bad) begin
            unique case (r_len)
                ldmc_pkg::IDX_W'(3): w_parsed = {8'h00, r_nib[0], r_nib[0], r_nib[1],
                                                 r_nib[1], r_nib[2], r_nib[2]};
                ldmc_pkg::IDX_W'(4): w_parsed = {r_nib[3], r_nib[3], r_nib[0], r_nib[0],
                                                 r_nib[1], r_nib[1], r_nib[2], r_nib[2]};
                ldmc_pkg::IDX_W'(6): w_parsed = {8'h00, r_nib[0], r_nib[1], r_nib[2],
                                                 r_nib[3], r_nib[4], r_nib[5]};
                ldmc_pkg::IDX_W'(8): w_parsed = {r_nib[6], r_nib[7], r_nib[0], r_nib[1],
                                                 r_nib[2], r_nib[3], r_nib[4], r_nib[5]};
                default:             w_parsed = '0;
            endcase
        end
    end

    // datapath
    always_comb begin
        n_store     = r_store;
        n_count     = r_count;
        n_mode      = r_mode;
        n_anim      = r_anim;
        n_frame     = r_frame;
        n_ticks     = r_ticks;
        n_color     = r_color;
        n_press     = r_press;
        n_led       = r_led;
        n_k         = r_k;
        n_len       = r_len;
        n_bad       = r_bad;
        n_found     = r_found;
        n_nib       = r_nib;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_mode  = r_out_mode;
        n_out_anim  = r_out_anim;
        n_out_frame = r_out_frame;
        n_out_color = r_out_color;
        n_out_led   = r_out_led;

        unique case (r_state)
            ldmc_pkg::ST_RUN: begin
                if (o_pop) begin
                    unique case (i_head.kind)
                        ldmc_pkg::CMD_BYTE: begin
                            // bytes past a full store are dropped
                            if (r_count < ldmc_pkg::CNT_W'(ldmc_pkg::LINE_LENGTH)) begin
                                n_store[r_count[ldmc_pkg::IDX_W-1:0]] = i_head.data;
                                n_count = r_count + 1'b1;
                            end
                        end
                        ldmc_pkg::CMD_EOL: begin
                            if (w_is_hash) begin
                                n_k     = ldmc_pkg::IDX_W'(1);
                                n_len   = '0;
                                n_bad   = 1'b0;
                                n_found = 1'b0;
                            end else begin
                                if (r_store[0] == ldmc_pkg::CHAR_BANG) begin
                                    n_mode  = ldmc_pkg::MODE_NOTIFY;
                                    n_frame = '0;
                                    n_ticks = r_notify_ticks;
                                end
                                n_store = '{default: 8'h00};
                                n_count = '0;
                            end
                        end
                        ldmc_pkg::CMD_PRESS: begin
                            n_press = 1'b1;
                        end
                        ldmc_pkg::CMD_TICK: begin
                            n_led = !r_led;
                            if (r_press) begin
                                n_mode  = ldmc_pkg::MODE_RING;
                                n_frame = '0;
                                n_press = 1'b0;
                                n_ticks = r_ring_ticks;
                                if (r_anim == ldmc_pkg::ANIM_LAST) begin
                                    n_anim = '0;
                                end else begin
                                    n_anim = r_anim + 1'b1;
                                end
                            end else if (r_ticks == '0) begin
                                n_mode = ldmc_pkg::MODE_IDLE;
                            end else begin
                                n_ticks = r_ticks - 1'b1;
                            end
                            n_out_valid = 1'b1;
                            n_out_mode  = n_mode;
                            n_out_anim  = n_anim[1:0];
                            n_out_frame = n_frame;
                            n_out_color = r_color;
                            n_out_led   = r_led;
                            n_frame     = n_frame + 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ldmc_pkg::ST_SCAN: begin
                // text length ends at the first zero byte after the '#' or at the end of the line store
                if (!r_found) begin
                    if (w_scan_byte == 8'h00) begin
                        n_found = 1'b1;
                    end else begin
                        if (r_len < ldmc_pkg::IDX_W'(ldmc_pkg::NIB_COUNT)) begin
                            n_nib[r_len[2:0]] = ldmc_pkg::hex_value(w_scan_byte);
                        end
                        n_bad = r_bad || !ldmc_pkg::hex_is_digit(w_scan_byte);
                        n_len = r_len + 1'b1;
                    end
                end
                if (r_k != ldmc_pkg::LINE_LAST_IDX) begin
                    n_k = r_k + 1'b1;
                end
            end
            ldmc_pkg::ST_DONE: begin
                n_color = w_parsed;
                n_mode  = ldmc_pkg::MODE_IDLE;
                n_store = '{default: 8'h00};
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ldmc_pkg::ST_RUN;
            r_store        <= '{default: 8'h00};
            r_count        <= '0;
            r_mode         <= ldmc_pkg::MODE_IDLE;
            r_anim         <= '0;
            r_frame        <= '0;
            r_ticks        <= '0;
            r_color        <= '0;
            r_press        <= 1'b0;
            r_led          <= 1'b0;
            r_out_valid    <= 1'b0;
            r_ring_ticks   <= ldmc_pkg::RING_TICKS_RESET;
            r_notify_ticks <= ldmc_pkg::NOTIFY_TICKS_RESET;
        end else begin
            r_state     <= n_state;
            r_store     <= n_store;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_anim      <= n_anim;
            r_frame     <= n_frame;
            r_ticks     <= n_ticks;
            r_color     <= n_color;
            r_press     <= n_press;
            r_led       <= n_led;
            r_out_valid <= n_out_valid;
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    ldmc_pkg::REG_RING_TICKS:   r_ring_ticks   <= i_cfg.data;
                    ldmc_pkg::REG_NOTIFY_TICKS: r_notify_ticks <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_len       <= n_len;
        r_bad       <= n_bad;
        r_found     <= n_found;
        r_nib       <= n_nib;
        r_out_mode  <= n_out_mode;
        r_out_anim  <= n_out_anim;
        r_out_frame <= n_out_frame;
        r_out_color <= n_out_color;
        r_out_led   <= n_out_led;
    end

    assign o_out_valid = r_out_valid;
    assign o_mode      = r_out_mode;
    assign o_anim      = r_out_anim;
    assign o_frame     = r_out_frame;
    assign o_color     = r_out_color;
    assign o_led       = r_out_led;

    a_no_pop_while_parsing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ldmc_pkg::ST_RUN) |-> !o_pop)
        else $error("command popped during color parse");

    a_tick_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.kind == ldmc_pkg::CMD_TICK) |-> w_out_free)
        else $error("tick executed while result register is blocked");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ldmc_pkg::CNT_W'(ldmc_pkg::LINE_LENGTH))
        else $error("line count beyond store length");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldmc_pkg::ST_DONE) |=> (r_count == '0 && r_mode == ldmc_pkg::MODE_IDLE))
        else $error("color line did not clear the store");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_frame)))
        else $error("stalled result changed");

endmodule

>>> bench/tb.sv
// self-checking bench for the led doorbell mode controller: serial lines, presses, frame reports
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [ldmc_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [ldmc_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int PHASE_ITEMS   = 200;

    typedef struct {
        ldmc_pkg::t_mode mode;
        logic [1:0]      anim;
        logic [15:0]     frame;
        logic [31:0]     color;
        logic            led;
    } t_frame_report;

    typedef struct {
        logic [1:0]    req;
        logic [7:0]    ch;
        logic          lvl;
        bit            typed;
        t_frame_report want;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // serial_byte [7:0], button_level [8], zero fill
    logic [ldmc_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    // req_type [1:0]
    logic [1:0]                       s_axis_tuser = ldmc_pkg::REQ_BYTE;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // animation_index [1:0], frame_index [17:2], wrgb_color [49:18],
    // activity_led [50], zero fill
    logic [ldmc_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    // mode [1:0]
    logic [1:0]                       m_axis_tuser;
    logic                             i_cfg_we = 1'b0;
    logic [ldmc_pkg::CFG_IDX_W-1:0]   i_cfg_idx = ldmc_pkg::REG_RING_TICKS;
    logic [ldmc_pkg::TICKS_W-1:0]     i_cfg_wdata = '0;

    led_doorbell_mode_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predicted controller state
    logic [7:0]       line_buf [0:ldmc_pkg::LINE_LENGTH-1];
    int               line_len;
    ldmc_pkg::t_mode  cur_mode;
    logic [1:0]       ring_anim;
    logic [15:0]      frame_num;
    logic [9:0]       ticks_remaining;
    logic [31:0]      held_color;
    logic             press_pending;
    logic             last_level;
    logic             led;
    logic [9:0]       ring_len;
    logic [9:0]       notify_len;

    t_frame_report reports_due [$];
    t_frame_report oldest_report;
    t_stim_row     opening_rows [$];

    int mismatches = 0;
    int requests_sent = 0;
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        return 5'h10;
    endfunction

    // text after the hash runs up to the first zero byte or the end of the line
    function automatic logic [31:0] decode_color();
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] chan [0:3];
        logic       bad;
        bit         paired;
        int         len;
        int         n;
        int         k;
        len = 0;
        while (len < ldmc_pkg::LINE_LENGTH - 1 && line_buf[len + 1] != 8'h00) len++;
        if (!(len inside {3, 4, 6, 8})) return 32'h0;
        paired = (len >= 6);
        n = (len == 4 || len == 8) ? 4 : 3;
        bad = 1'b0;
        for (k = 0; k < 4; k++) chan[k] = 8'h00;
        for (k = 0; k < n; k++) begin
            hi = hex_nibble(line_buf[1 + (paired ? 2 * k : k)]);
            lo = paired ? hex_nibble(line_buf[2 + 2 * k]) : hi;
            bad |= hi[4] | lo[4];
            chan[k] = {hi[3:0], lo[3:0]};
        end
        return bad ? 32'h0 : {chan[3], chan[0], chan[1], chan[2]};
    endfunction

    function automatic void reset_controller();
        foreach (line_buf[k]) line_buf[k] = 8'h00;
        line_len = 0;
        cur_mode = ldmc_pkg::MODE_IDLE;
        ring_anim = '0;
        frame_num = '0;
        ticks_remaining = '0;
        held_color = '0;
        press_pending = 1'b0;
        last_level = 1'b1;
        led = 1'b0;
        ring_len = ldmc_pkg::RING_TICKS_RESET;
        notify_len = ldmc_pkg::NOTIFY_TICKS_RESET;
    endfunction

    function automatic void advance_controller(input logic [1:0] req, input logic [7:0] ch,
                                               input logic lvl);
        t_frame_report rep;
        case (req)
            ldmc_pkg::REQ_BYTE: begin
                if (ch == ldmc_pkg::CHAR_CR || ch == ldmc_pkg::CHAR_LF) begin
                    if (line_buf[0] == ldmc_pkg::CHAR_HASH) begin
                        held_color = decode_color();
                        cur_mode = ldmc_pkg::MODE_IDLE;
                    end else if (line_buf[0] == ldmc_pkg::CHAR_BANG) begin
                        cur_mode = ldmc_pkg::MODE_NOTIFY;
                        frame_num = '0;
                        ticks_remaining = notify_len;
                    end
                    foreach (line_buf[k]) line_buf[k] = 8'h00;
                    line_len = 0;
                end else if (line_len < ldmc_pkg::LINE_LENGTH) begin
                    line_buf[line_len] = ch;
                    line_len++;
                end
            end
            ldmc_pkg::REQ_BUTTON: begin
                if (!lvl && last_level) press_pending = 1'b1;
                last_level = lvl;
            end
            ldmc_pkg::REQ_TICK: begin
                // led is reported before it toggles
                rep.led = led;
                led = ~led;
                if (press_pending) begin
                    cur_mode = ldmc_pkg::MODE_RING;
                    frame_num = '0;
                    press_pending = 1'b0;
                    ticks_remaining = ring_len;
                    ring_anim = 2'((32'(ring_anim) + 1) % ldmc_pkg::ANIMATION_COUNT);
                end else if (ticks_remaining == 0) begin
                    cur_mode = ldmc_pkg::MODE_IDLE;
                end else begin
                    ticks_remaining--;
                end
                rep.mode = cur_mode;
                rep.anim = ring_anim;
                rep.frame = frame_num;
                rep.color = held_color;
                reports_due.push_back(rep);
                frame_num++;
            end
            default: ;
        endcase
    endfunction

    function automatic t_stim_row request_row(input logic [1:0] req, input logic [7:0] ch,
                                              input logic lvl);
        t_stim_row row;
        row.req = req;
        row.ch = ch;
        row.lvl = lvl;
        row.typed = 1'b0;
        row.want = '{ldmc_pkg::MODE_IDLE, 2'd0, 16'd0, 32'd0, 1'b0};
        return row;
    endfunction

    function automatic t_stim_row tick_row(input ldmc_pkg::t_mode mode,
                                           input logic [1:0] anim,
                                           input logic [15:0] frame, input logic [31:0] color,
                                           input logic lvl_led);
        t_stim_row row;
        row = request_row(ldmc_pkg::REQ_TICK, 8'h00, 1'b0);
        row.typed = 1'b1;
        row.want = '{mode, anim, frame, color, lvl_led};
        return row;
    endfunction

    function automatic void add_line(input string text, input logic [7:0] term);
        for (int k = 0; k < text.len(); k++) begin
            opening_rows.push_back(request_row(ldmc_pkg::REQ_BYTE, text[k], 1'b1));
        end
        opening_rows.push_back(request_row(ldmc_pkg::REQ_BYTE, term, 1'b0));
    endfunction

    function automatic logic [7:0] random_hex_char();
        int k;
        k = $urandom_range(21);
        if (k < 10) return 8'("0" + k);
        if (k < 16) return 8'("a" + k - 10);
        return 8'("A" + k - 16);
    endfunction

    task automatic send(input logic [1:0] req, input logic [7:0] ch, input logic lvl);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(ldmc_pkg::S_TDATA_W - 9){1'b0}}, lvl, ch};
        s_axis_tuser <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_controller(req, ch, lvl);
        if (req != REQ_UNUSED) requests_sent++;
    endtask

    // a line end may still be scanning after the last report, so hold off a while
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [9:0] ring, input logic [9:0] notify);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ldmc_pkg::REG_RING_TICKS;
        i_cfg_wdata <= ring;
        @(posedge i_clk);
        ring_len = ring;
        i_cfg_idx <= ldmc_pkg::REG_NOTIFY_TICKS;
        i_cfg_wdata <= notify;
        @(posedge i_clk);
        notify_len = notify;
        // unknown index, must leave both registers alone
        i_cfg_idx <= $urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B;
        i_cfg_wdata <= ldmc_pkg::TICKS_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_sequence();
        int pick;
        int n;
        int k;
        int bad_pos;
        logic [7:0] term;
        pick = $urandom_range(99);
        term = $urandom_range(1) ? ldmc_pkg::CHAR_CR : ldmc_pkg::CHAR_LF;
        if (pick < 25) begin
            k = $urandom_range(9);
            case (k)
                0, 1: n = $urandom_range(17);
                2, 3: n = 3;
                4, 5: n = 4;
                6, 7: n = 6;
                default: n = 8;
            endcase
            bad_pos = (n != 0 && $urandom_range(6) == 0) ? int'($urandom_range(n - 1)) : -1;
            send(ldmc_pkg::REQ_BYTE, ldmc_pkg::CHAR_HASH, 1'($urandom_range(1)));
            for (k = 0; k < n; k++) begin
                send(ldmc_pkg::REQ_BYTE,
                     (k == bad_pos) ? 8'($urandom_range(255)) : random_hex_char(),
                     1'($urandom_range(1)));
            end
            send(ldmc_pkg::REQ_BYTE, term, 1'($urandom_range(1)));
        end else if (pick < 35) begin
            send(ldmc_pkg::REQ_BYTE, ldmc_pkg::CHAR_BANG, 1'($urandom_range(1)));
            n = $urandom_range(4);
            for (k = 0; k < n; k++) begin
                send(ldmc_pkg::REQ_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            send(ldmc_pkg::REQ_BYTE, term, 1'($urandom_range(1)));
        end else if (pick < 50) begin
            send(ldmc_pkg::REQ_BUTTON, 8'($urandom_range(255)), 1'b1);
            send(ldmc_pkg::REQ_BUTTON, 8'($urandom_range(255)), 1'b0);
            if ($urandom_range(1)) begin
                send(ldmc_pkg::REQ_BUTTON, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end else if (pick < 78) begin
            n = $urandom_range(1, 4);
            repeat (n) send(ldmc_pkg::REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (pick < 84) begin
            // empty line or a line of one to four random bytes
            if ($urandom_range(3) != 0) begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    send(ldmc_pkg::REQ_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
            send(ldmc_pkg::REQ_BYTE, term, 1'($urandom_range(1)));
        end else if (pick < 89) begin
            // overlong line, bytes past the end of the store are dropped
            send(ldmc_pkg::REQ_BYTE,
                 $urandom_range(1) ? ldmc_pkg::CHAR_HASH : ldmc_pkg::CHAR_BANG,
                 1'($urandom_range(1)));
            n = $urandom_range(16, 20);
            for (k = 0; k < n; k++) begin
                send(ldmc_pkg::REQ_BYTE, random_hex_char(), 1'($urandom_range(1)));
            end
            send(ldmc_pkg::REQ_BYTE, term, 1'($urandom_range(1)));
        end else if (pick < 94) begin
            send(ldmc_pkg::REQ_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (pick < 97) begin
            send(ldmc_pkg::REQ_BUTTON, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            send(REQ_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
        end
    endtask

    // frame report checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reports_due.size() == 0) begin
                mismatches++;
                $display("%0t: frame report expected none got mode %0h data %0h", $time,
                         m_axis_tuser, m_axis_tdata);
            end else begin
                oldest_report = reports_due.pop_front();
                check_field("mode", 32'(oldest_report.mode), 32'(m_axis_tuser));
                check_field("animation_index", 32'(oldest_report.anim), 32'(m_axis_tdata[1:0]));
                check_field("frame_index", 32'(oldest_report.frame), 32'(m_axis_tdata[17:2]));
                check_field("wrgb_color", oldest_report.color, m_axis_tdata[49:18]);
                check_field("activity_led", 32'(oldest_report.led), 32'(m_axis_tdata[50]));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [9:0] ring;
        logic [9:0] notify;
        int target;
        reset_controller();

        opening_rows.push_back(tick_row(ldmc_pkg::MODE_IDLE, 2'd0, 16'd0, 32'h0, 1'b0));
        opening_rows.push_back(request_row(REQ_UNUSED, 8'hFF, 1'b1));
        opening_rows.push_back(request_row(ldmc_pkg::REQ_BUTTON, 8'h00, 1'b1));
        opening_rows.push_back(request_row(ldmc_pkg::REQ_BUTTON, 8'hFF, 1'b0));
        opening_rows.push_back(request_row(ldmc_pkg::REQ_BUTTON, 8'h00, 1'b0));
        opening_rows.push_back(tick_row(ldmc_pkg::MODE_RING, 2'd1, 16'd0, 32'h0, 1'b1));
        add_line("#FFFFFFFF", ldmc_pkg::CHAR_CR);
        opening_rows.push_back(tick_row(ldmc_pkg::MODE_IDLE, 2'd1, 16'd1, 32'hFFFF_FFFF,
                                        1'b0));
        add_line("!", ldmc_pkg::CHAR_LF);
        opening_rows.push_back(tick_row(ldmc_pkg::MODE_NOTIFY, 2'd1, 16'd0, 32'hFFFF_FFFF,
                                        1'b1));
        // bad hex digit clears the color
        add_line("#1g3", ldmc_pkg::CHAR_CR);
        opening_rows.push_back(tick_row(ldmc_pkg::MODE_IDLE, 2'd1, 16'd1, 32'h0, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[r]) begin
            send(opening_rows[r].req, opening_rows[r].ch, opening_rows[r].lvl);
            if (opening_rows[r].typed) reports_due[reports_due.size() - 1] = opening_rows[r].want;
        end
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin ring = 10'd0; notify = 10'd0; end
                1: begin ring = 10'd1023; notify = 10'd1023; end
                2: begin ring = 10'($urandom_range(7)); notify = 10'($urandom_range(7)); end
                3: begin ring = 10'($urandom_range(3)); notify = 10'($urandom_range(20)); end
                4: begin
                    ring = 10'($urandom_range(1023));
                    notify = 10'($urandom_range(1023));
                end
                default: begin
                    ring = 10'($urandom_range(10));
                    notify = 10'($urandom_range(10));
                end
            endcase
            write_settings(ring, notify);
            case (phase % 4)
                0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
                1: begin snd_idle_pct = 68; rcv_stall_pct = 0; end
                2: begin snd_idle_pct = 0; rcv_stall_pct = 68; end
                default: begin snd_idle_pct = 11; rcv_stall_pct = 11; end
            endcase
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target) send_random_sequence();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
